// ----- hdl/sptr_pkg.sv -----
// Package for the spectrum peak frequency tracker: payload and configuration
// structs, register indexes, reset values and shared constants.
// Depends on nothing.
`timescale 1ns / 1ps

package sptr_pkg;

    localparam int HALF_BINS_DEF      = 512;
    localparam int BIN_WIDTH_BITS_DEF = 24;

    // Depth of the frame queue between the bin pipeline and the finisher.
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int FRAC_BITS   = 8;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_SHIFT = 16;
    localparam int FREQ_W      = 24;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQUENCY   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQUENCY   = 8'd3;

    localparam logic [23:0] RST_BIN_WIDTH       = 24'd11025;
    localparam logic [16:0] RST_SMOOTHING_ALPHA = 17'd32768;
    localparam logic [15:0] RST_MAX_FREQUENCY   = 16'd20000;
    localparam logic [15:0] RST_MIN_FREQUENCY   = 16'd20;

    typedef struct packed {
        logic [23:0] bin_width;
        logic [16:0] smoothing_alpha;
        logic [15:0] max_frequency;
        logic [15:0] min_frequency;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] bin_real;
        logic signed [23:0] bin_imag;
        logic               last_bin;
    } t_in_item;

    typedef struct packed {
        logic [15:0] dominant_frequency;
        logic [8:0]  dominant_bin;
    } t_out_item;

endpackage

// ----- hdl/sptr_fifo.sv -----
// Small register queue that carries the peak bin of each finished frame
// from the bin pipeline to the frequency finisher. Depends on nothing.
`timescale 1ns / 1ps

module sptr_fifo #(
    parameter int DATA_W = 9,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)) || i_pop)
        else $error("frame queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("frame queue read while empty");
`endif

endmodule

// ----- hdl/sptr_front.sv -----
// Bin pipeline: accepts FFT bins, forms their power and keeps the running
// peak of the frame; hands the peak bin of each frame to the queue. Uses sptr_pkg.
`timescale 1ns / 1ps

module sptr_front #(
    parameter int HALF_BINS = sptr_pkg::HALF_BINS_DEF,
    parameter int IDX_W     = $clog2(HALF_BINS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sptr_pkg::t_in_item i_in,
    output logic               o_push,
    output logic [IDX_W-1:0]   o_push_bin,
    input  logic               i_pop
);

    localparam int CNT_W  = $clog2(HALF_BINS + 1);
    localparam int SQ_W   = 47;
    localparam int PW_W   = SQ_W + 1;
    localparam int PEND_W = $clog2(sptr_pkg::QUEUE_DEPTH + 1);

    logic                     w_accept;
    logic                     w_in_range;
    logic signed [23:0]       w_re, w_im;
    logic signed [47:0]       w_sq_re, w_sq_im;
    logic                     w_take;
    logic [IDX_W-1:0]         w_best_bin;
    logic                     w_last_in;

    logic [CNT_W-1:0]  r_cnt;
    logic [PEND_W-1:0] r_pend, n_pend;

    logic              r_s1_valid, r_s1_use, r_s1_last;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [SQ_W-1:0]   r_sq_re, r_sq_im;

    logic              r_s2_valid, r_s2_use, r_s2_last;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [PW_W-1:0]   r_pw;

    logic [PW_W-1:0]   r_best_pw;
    logic [IDX_W-1:0]  r_best_bin;

    // Each pending frame holds one queue slot from its last bin until the
    // finisher takes it, so the queue can never overflow.
    assign o_in_ready = (r_pend < PEND_W'(sptr_pkg::QUEUE_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (r_cnt < CNT_W'(HALF_BINS));
    assign w_last_in  = i_in.last_bin;
    assign w_re       = i_in.bin_real;
    assign w_im       = i_in.bin_imag;
    assign w_sq_re    = w_re * w_re;
    assign w_sq_im    = w_im * w_im;

    always_comb begin
        n_pend = r_pend;
        if (w_accept && w_last_in && !i_pop) begin
            n_pend = r_pend + 1'b1;
        end else if (!(w_accept && w_last_in) && i_pop) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_pend     <= n_pend;
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            if (w_accept) begin
                if (w_last_in) begin
                    r_cnt <= '0;
                end else if (w_in_range) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sq_re   <= w_sq_re[SQ_W-1:0];
            r_sq_im   <= w_sq_im[SQ_W-1:0];
            r_s1_idx  <= r_cnt[IDX_W-1:0];
            r_s1_use  <= w_in_range;
            r_s1_last <= w_last_in;
        end
        if (r_s1_valid) begin
            r_pw      <= PW_W'(r_sq_re) + PW_W'(r_sq_im);
            r_s2_idx  <= r_s1_idx;
            r_s2_use  <= r_s1_use;
            r_s2_last <= r_s1_last;
        end
    end

    // Strictly greater keeps the first bin of equal peaks.
    assign w_take     = r_s2_valid && r_s2_use && (r_pw > r_best_pw);
    assign w_best_bin = w_take ? r_s2_idx : r_best_bin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_pw  <= '0;
            r_best_bin <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_last) begin
                r_best_pw  <= '0;
                r_best_bin <= '0;
            end else if (w_take) begin
                r_best_pw  <= r_pw;
                r_best_bin <= r_s2_idx;
            end
        end
    end

    assign o_push     = r_s2_valid && r_s2_last;
    assign o_push_bin = w_best_bin;

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(sptr_pkg::QUEUE_DEPTH))
        else $error("more frames pending than queue slots");
`endif

endmodule

// ----- hdl/sptr_back.sv -----
// Frequency finisher: turns a frame's peak bin into a smoothed, clamped
// frequency and holds it in the output register. Uses sptr_pkg.
`timescale 1ns / 1ps

module sptr_back #(
    parameter int HALF_BINS      = sptr_pkg::HALF_BINS_DEF,
    parameter int BIN_WIDTH_BITS = sptr_pkg::BIN_WIDTH_BITS_DEF,
    parameter int IDX_W          = $clog2(HALF_BINS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sptr_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  logic [IDX_W-1:0]    i_bin,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sptr_pkg::t_out_item o_out
);

    localparam int BW     = BIN_WIDTH_BITS;
    localparam int AW     = sptr_pkg::ALPHA_W;
    localparam int LF_W   = sptr_pkg::FREQ_W;
    localparam int F_W    = IDX_W + BW;
    localparam int FLO_W  = F_W / 2;
    localparam int FHI_W  = F_W - FLO_W;
    localparam int PLO_W  = AW + FLO_W;
    localparam int PHI_W  = AW + FHI_W;
    localparam int PL_W   = AW + LF_W;
    localparam int SUM_W  = AW + ((F_W > LF_W) ? F_W : LF_W);
    localparam int SM_W   = SUM_W - sptr_pkg::ALPHA_SHIFT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_F = 3'd1;
    localparam logic [2:0] ST_MUL_P = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         r_state;
    logic [IDX_W-1:0]   r_bin;
    logic [F_W-1:0]     r_f;
    logic [AW-1:0]      r_alpha, r_beta;
    logic [PLO_W-1:0]   r_p_lo;
    logic [PHI_W-1:0]   r_p_hi;
    logic [PL_W-1:0]    r_p_last;
    logic [SUM_W-1:0]   r_sum;
    logic [LF_W-1:0]    r_last_freq;
    logic               r_out_valid;
    sptr_pkg::t_out_item r_out;

    logic [BW+23:0]     w_width_ext;
    logic [BW-1:0]      w_width;
    logic [SM_W-1:0]    w_sm, w_hi, w_lo, w_clamp, w_res;
    logic [IDX_W+8:0]   w_bin_ext;
    logic               w_load;

    // Only the low BIN_WIDTH_BITS bits of the register take part.
    assign w_width_ext = {{BW{1'b0}}, i_cfg.bin_width};
    assign w_width     = w_width_ext[BW-1:0];

    assign w_sm    = r_sum[SUM_W-1:sptr_pkg::ALPHA_SHIFT];
    assign w_hi    = SM_W'({i_cfg.max_frequency, {sptr_pkg::FRAC_BITS{1'b0}}});
    assign w_lo    = SM_W'({i_cfg.min_frequency, {sptr_pkg::FRAC_BITS{1'b0}}});
    // Clamp to the maximum first; a minimum above the maximum then zeroes it.
    assign w_clamp = (w_sm > w_hi) ? w_hi : w_sm;
    assign w_res   = (w_clamp < w_lo) ? '0 : w_clamp;

    assign w_bin_ext = {9'b0, r_bin};

    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign w_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_freq <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_MUL_F;
                    end
                end
                ST_MUL_F: r_state <= ST_MUL_P;
                ST_MUL_P: r_state <= ST_SUM;
                ST_SUM:   r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_load) begin
                        r_state     <= ST_IDLE;
                        r_last_freq <= w_res[LF_W-1:0];
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bin   <= i_bin;
            r_alpha <= (i_cfg.smoothing_alpha > sptr_pkg::ALPHA_ONE)
                       ? sptr_pkg::ALPHA_ONE : i_cfg.smoothing_alpha;
        end
        if (r_state == ST_MUL_F) begin
            r_f    <= F_W'(r_bin) * F_W'(w_width);
            r_beta <= sptr_pkg::ALPHA_ONE - r_alpha;
        end
        // The raw frequency is split in two halves to keep each product narrow.
        if (r_state == ST_MUL_P) begin
            r_p_lo   <= PLO_W'(r_alpha) * PLO_W'(r_f[FLO_W-1:0]);
            r_p_hi   <= PHI_W'(r_alpha) * PHI_W'(r_f[F_W-1:FLO_W]);
            r_p_last <= PL_W'(r_beta) * PL_W'(r_last_freq);
        end
        if (r_state == ST_SUM) begin
            r_sum <= SUM_W'(r_p_lo) + (SUM_W'(r_p_hi) << FLO_W) + SUM_W'(r_p_last);
        end
        if (w_load) begin
            r_out.dominant_frequency <= w_res[sptr_pkg::FRAC_BITS +: 16];
            r_out.dominant_bin       <= w_bin_ext[8:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_freq_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.dominant_frequency <= i_cfg.max_frequency)
        || (r_out.dominant_frequency == '0))
        else $error("reported frequency above the upper clamp");
    a_free_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && !r_out_valid |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finished frame not moved to a free output register");
`endif

endmodule

// ----- hdl/spectrum_peak_frequency_tracker_unit.sv -----
// Top level of the spectrum peak frequency tracker: configuration registers,
// bin pipeline, frame queue and frequency finisher. Uses sptr_pkg.
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_ready / i_in): one FFT bin per request,
// lower half spectrum in order, last_bin set on the final bin of a frame.
// Output channel (o_out_valid / i_out_ready / o_out): one request per frame,
// giving the smoothed, clamped peak frequency in whole Hz and the peak bin.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; index 0 bin width, 1 smoothing alpha, 2 maximum, 3 minimum.
// Write it only while no frame is in flight.
// Throughput: one bin per cycle while the input is not stalled. The finisher
// runs its multiply and sum sequence for each frame; a four-entry frame queue
// absorbs closely spaced frames, and the input stalls only when four frames
// wait for it. Each result passes the bin pipeline, the queue and the finisher.
// When the receiver stalls, the result holds in the output register, the
// finisher waits behind it, and bins keep flowing until the queue is full.
// Reset clears the frame state, the smoothing history and the queue, and
// loads the register defaults; the block accepts bins the cycle after.
module spectrum_peak_frequency_tracker_unit #(
    parameter int HALF_BINS      = sptr_pkg::HALF_BINS_DEF,
    parameter int BIN_WIDTH_BITS = sptr_pkg::BIN_WIDTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sptr_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sptr_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sptr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sptr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(HALF_BINS);

    sptr_pkg::t_cfg   r_cfg;
    logic             w_push, w_pop, w_empty;
    logic [IDX_W-1:0] w_push_bin, w_pop_bin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_width       <= sptr_pkg::RST_BIN_WIDTH;
            r_cfg.smoothing_alpha <= sptr_pkg::RST_SMOOTHING_ALPHA;
            r_cfg.max_frequency   <= sptr_pkg::RST_MAX_FREQUENCY;
            r_cfg.min_frequency   <= sptr_pkg::RST_MIN_FREQUENCY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sptr_pkg::CFG_BIN_WIDTH:       r_cfg.bin_width       <= i_cfg_data;
                sptr_pkg::CFG_SMOOTHING_ALPHA: r_cfg.smoothing_alpha <= i_cfg_data[16:0];
                sptr_pkg::CFG_MAX_FREQUENCY:   r_cfg.max_frequency   <= i_cfg_data[15:0];
                sptr_pkg::CFG_MIN_FREQUENCY:   r_cfg.min_frequency   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sptr_front #(
        .HALF_BINS (HALF_BINS),
        .IDX_W     (IDX_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_push     (w_push),
        .o_push_bin (w_push_bin),
        .i_pop      (w_pop)
    );

    sptr_fifo #(
        .DATA_W (IDX_W),
        .DEPTH  (sptr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_bin),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_bin)
    );

    sptr_back #(
        .HALF_BINS      (HALF_BINS),
        .BIN_WIDTH_BITS (BIN_WIDTH_BITS),
        .IDX_W          (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_bin       (w_pop_bin),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- test/tb_spectrum_peak_frequency_tracker_unit.sv -----
// Self-checking testbench for the spectrum peak frequency tracker: drives FFT bin frames with
// random bursts, receiver stalls and register changes, and checks every result against a predictor.
// Depends on sptr_pkg and spectrum_peak_frequency_tracker_unit.
`timescale 1ns / 1ps

module tb_spectrum_peak_frequency_tracker_unit;
    import sptr_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 30;
    localparam int PHASE_ITEMS   = 50;
    localparam int RANDOM_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

    typedef enum int {FRAME_NOISE, FRAME_SILENT, FRAME_TIES} t_frame_kind;
    typedef enum int {RX_ALWAYS, RX_PATTERN} t_rx_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out_item             o_out;

    // Predictor state and its copy of the registers.
    int unsigned  pk_count     = 0;
    logic [48:0]  pk_best_pow  = '0;
    logic [8:0]   pk_best_idx  = '0;
    logic [23:0]  pk_last_freq = '0;
    logic [23:0]  cf_bin_width = RST_BIN_WIDTH;
    logic [16:0]  cf_alpha     = RST_SMOOTHING_ALPHA;
    logic [15:0]  cf_max       = RST_MAX_FREQUENCY;
    logic [15:0]  cf_min       = RST_MIN_FREQUENCY;

    t_out_item    freq_expect[$];
    int           mismatches  = 0;

    int           burst_left  = 0;
    bit           gaps_on     = 1'b1;
    t_rx_mode     rx_mode     = RX_PATTERN;
    int           hold_ticket = 0;

    spectrum_peak_frequency_tracker_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial begin
        #2000000;
        $display("spectrum_peak_frequency_tracker_unit test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Runs the peak search on one accepted bin and queues the frame result on the last one.
    function automatic void track_bin(input t_in_item it);
        longint      re;
        longint      im;
        logic [48:0] pow;
        logic [63:0] width_mask;
        logic [63:0] raw;
        logic [63:0] alpha;
        logic [63:0] blend;
        logic [63:0] upper;
        logic [63:0] lower;
        t_out_item   res;
        re  = it.bin_real;
        im  = it.bin_imag;
        pow = 49'(re * re + im * im);
        if (pk_count < HALF_BINS_DEF) begin
            if (pow > pk_best_pow) begin
                pk_best_pow = pow;
                pk_best_idx = 9'(pk_count);
            end
            pk_count++;
        end
        if (!it.last_bin) return;
        width_mask = (64'd1 << BIN_WIDTH_BITS_DEF) - 64'd1;
        raw   = 64'(pk_best_idx) * (64'(cf_bin_width) & width_mask);
        alpha = (cf_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(cf_alpha);
        blend = (alpha * raw + (64'(ALPHA_ONE) - alpha) * 64'(pk_last_freq)) >> ALPHA_SHIFT;
        upper = 64'(cf_max) << FRAC_BITS;
        lower = 64'(cf_min) << FRAC_BITS;
        // The maximum clamp comes first, so a minimum above the maximum zeroes everything.
        if (blend > upper) blend = upper;
        if (blend < lower) blend = '0;
        pk_last_freq           = blend[23:0];
        res.dominant_frequency = blend[FRAC_BITS +: 16];
        res.dominant_bin       = pk_best_idx;
        freq_expect.push_back(res);
        pk_count    = 0;
        pk_best_pow = '0;
        pk_best_idx = '0;
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (freq_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected result freq=%0d bin=%0d",
                                          o_out.dominant_frequency, o_out.dominant_bin));
            end else begin
                want = freq_expect.pop_front();
                if (o_out.dominant_frequency !== want.dominant_frequency)
                    report_mismatch($sformatf("dominant_frequency got %0d want %0d",
                                              o_out.dominant_frequency, want.dominant_frequency));
                if (o_out.dominant_bin !== want.dominant_bin)
                    report_mismatch($sformatf("dominant_bin got %0d want %0d",
                                              o_out.dominant_bin, want.dominant_bin));
            end
        end
    end

    // Receiver: a rotating ready pattern, rerolled now and then, plus a one-off long hold.
    logic [15:0] rx_pattern  = 16'hFFFF;
    int          rx_age      = 0;
    int          hold_left   = 0;
    int          hold_served = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            out_ready <= 1'b1;
        end else begin
            rx_age++;
            if (rx_age % 64 == 0) rx_pattern = 16'($urandom) | 16'h0001;
            else rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            out_ready <= rx_pattern[0];
        end
    end

    // Offers one bin, waits for the request to be taken, then maybe opens a gap.
    task automatic send_bin(input t_in_item it);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        track_bin(it);
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (freq_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BIN_WIDTH:       cf_bin_width = data;
            CFG_SMOOTHING_ALPHA: cf_alpha     = data[16:0];
            CFG_MAX_FREQUENCY:   cf_max       = data[15:0];
            CFG_MIN_FREQUENCY:   cf_min       = data[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [23:0] bw, input logic [23:0] alpha,
                             input logic [23:0] fmax, input logic [23:0] fmin);
        write_reg(CFG_BIN_WIDTH, bw);
        write_reg(CFG_SMOOTHING_ALPHA, alpha);
        write_reg(CFG_MAX_FREQUENCY, fmax);
        write_reg(CFG_MIN_FREQUENCY, fmin);
    endtask

    function automatic t_in_item mk_bin(input int re, input int im, input bit last);
        t_in_item it;
        it.bin_real = 24'(re);
        it.bin_imag = 24'(im);
        it.last_bin = last;
        return it;
    endfunction

    function automatic logic signed [23:0] rand_part(input t_frame_kind kind);
        logic signed [23:0] v;
        case (kind)
            FRAME_SILENT: v = '0;
            FRAME_TIES:   v = 24'($urandom_range(0, 4)) - 24'd2;
            default: begin
                case ($urandom_range(0, 15))
                    0:       v = 24'h800000;
                    1:       v = 24'h7FFFFF;
                    2:       v = '0;
                    default: v = $signed(24'($urandom)) >>> $urandom_range(0, 22);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_frame(input int nbins, input t_frame_kind kind);
        t_in_item it;
        for (int k = 0; k < nbins; k++) begin
            it.bin_real = rand_part(kind);
            it.bin_imag = rand_part(kind);
            it.last_bin = (k == nbins - 1);
            send_bin(it);
        end
    endtask

    task automatic test_default_regs();
        send_bin(mk_bin(100, 0, 1'b1));
        send_bin(mk_bin(1, 1, 1'b0));
        send_bin(mk_bin(-8388608, -8388608, 1'b0));
        send_bin(mk_bin(8388607, 8388607, 1'b0));
        send_bin(mk_bin(0, 0, 1'b1));
        // Silent frame: no power anywhere, so the raw frequency is zero.
        send_bin(mk_bin(0, 0, 1'b0));
        send_bin(mk_bin(0, 0, 1'b0));
        send_bin(mk_bin(0, 0, 1'b1));
        // Equal powers later in the frame must not displace the first peak.
        send_bin(mk_bin(1, 0, 1'b0));
        send_bin(mk_bin(3, 4, 1'b0));
        send_bin(mk_bin(-4, -3, 1'b0));
        send_bin(mk_bin(0, 5, 1'b1));
        send_bin(mk_bin(0, 1, 1'b0));
        send_bin(mk_bin(0, 2, 1'b0));
        send_bin(mk_bin(0, -3, 1'b1));
    endtask

    task automatic send_peak_frame();
        send_bin(mk_bin(0, 0, 1'b0));
        send_bin(mk_bin(1, 1, 1'b0));
        send_bin(mk_bin(2, -2, 1'b0));
        send_bin(mk_bin(-9, 9, 1'b1));
    endtask

    task automatic test_register_extremes();
        drain_and_settle();
        // Alpha above one, with upper data bits set on every register.
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0000);
        send_peak_frame();
        drain_and_settle();
        write_reg(CFG_SMOOTHING_ALPHA, 24'd0);
        send_peak_frame();
        drain_and_settle();
        write_reg(CFG_SMOOTHING_ALPHA, 24'd65537);
        write_reg(CFG_BIN_WIDTH, 24'd0);
        send_peak_frame();
        drain_and_settle();
        write_all(24'd11025, 24'(ALPHA_ONE), 24'd0, 24'd0);
        send_peak_frame();
        drain_and_settle();
        write_reg(CFG_MAX_FREQUENCY, 24'd65535);
        write_reg(CFG_MIN_FREQUENCY, 24'd65535);
        send_peak_frame();
        drain_and_settle();
        // Minimum above maximum: the clamped value still falls under the minimum.
        write_all(24'hFFFFFF, 24'(ALPHA_ONE), 24'd100, 24'd500);
        send_peak_frame();
        drain_and_settle();
        write_reg(CFG_IDX_UNUSED, 24'($urandom));
        write_reg(CFG_IDX_W'($urandom_range(4, 254)), 24'($urandom));
        send_peak_frame();
        drain_and_settle();
        write_all(RST_BIN_WIDTH, 24'(RST_SMOOTHING_ALPHA), 24'(RST_MAX_FREQUENCY),
                  24'(RST_MIN_FREQUENCY));
    endtask

    task automatic test_overlong_frames();
        drain_and_settle();
        write_all(24'd2560, 24'(ALPHA_ONE), 24'd65535, 24'd0);
        // Full frame whose peak sits on the very last bin.
        for (int k = 0; k < HALF_BINS_DEF; k++) begin
            if (k == HALF_BINS_DEF - 1) send_bin(mk_bin(1000, -1000, 1'b1));
            else send_bin(mk_bin(int'(rand_part(FRAME_TIES)), int'(rand_part(FRAME_TIES)), 1'b0));
        end
        // Bins past the frame length carry huge power but must be ignored.
        for (int k = 0; k < HALF_BINS_DEF + 8; k++) begin
            if (k < HALF_BINS_DEF)
                send_bin(mk_bin(int'(rand_part(FRAME_TIES)), int'(rand_part(FRAME_TIES)), 1'b0));
            else
                send_bin(mk_bin(-8388608, 8388607, k == HALF_BINS_DEF + 7));
        end
        send_frame(3, FRAME_NOISE);
        send_frame(HALF_BINS_DEF, FRAME_NOISE);
    endtask

    task automatic test_backpressure();
        drain_and_settle();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_ticket++;
        for (int k = 0; k < 48; k++) send_frame($urandom_range(1, 2), FRAME_NOISE);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [23:0] bw;
        logic [23:0] alpha;
        logic [23:0] fmax;
        logic [23:0] fmin;
        int          sent;
        int          nbins;
        int          pick;
        t_frame_kind kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_and_settle();
            if (phase == 0) begin
                write_all(24'hFFFFFF, 24'(ALPHA_ONE), 24'hFFFF, 24'd0);
            end else if (phase == 1) begin
                write_all(24'd1, 24'd1, 24'd1, 24'd0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       bw = 24'hFFFFFF;
                    1:       bw = 24'd0;
                    2, 3, 4: bw = 24'($urandom_range(1, 4096));
                    default: bw = 24'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 5))
                    0:       alpha = 24'd0;
                    1:       alpha = 24'(ALPHA_ONE);
                    2:       alpha = 24'($urandom_range(65537, 131071));
                    default: alpha = 24'($urandom_range(1, 65535));
                endcase
                alpha[23:17] = 7'($urandom);
                case ($urandom_range(0, 5))
                    0:       fmax = 24'd65535;
                    1:       fmax = 24'd0;
                    default: fmax = 24'($urandom_range(100, 65535));
                endcase
                case ($urandom_range(0, 7))
                    0:       fmin = 24'd0;
                    1:       fmin = 24'd65535;
                    2:       fmin = 24'($urandom_range(0, 65535));
                    default: fmin = 24'($urandom_range(0, 2000));
                endcase
                fmax[23:16] = 8'($urandom);
                fmin[23:16] = 8'($urandom);
                write_all(bw, alpha, fmax, fmin);
            end
            rx_mode = (phase % 3 == 2) ? RX_ALWAYS : RX_PATTERN;
            gaps_on = (phase % 4 != 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 1) nbins = HALF_BINS_DEF + $urandom_range(1, 10);
                else if (pick < 2) nbins = HALF_BINS_DEF;
                else if (pick < 75) nbins = $urandom_range(1, 12);
                else nbins = $urandom_range(13, 64);
                pick = $urandom_range(0, 9);
                kind = (pick == 0) ? FRAME_SILENT : (pick == 1) ? FRAME_TIES : FRAME_NOISE;
                send_frame(nbins, kind);
                sent += nbins;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_regs();
        test_register_extremes();
        test_overlong_frames();
        test_backpressure();
        test_random_phases();
        drain_and_settle();
        if (mismatches == 0) begin
            $display("spectrum_peak_frequency_tracker_unit test passed");
        end else begin
            $display("spectrum_peak_frequency_tracker_unit test failed");
        end
        $finish;
    end

endmodule
